FILE: rtl/biou_pkg.sv
// ----------------------------------------------------------------------------
// biou_pkg: shared widths and types of the box IoU cost pipeline
// Field widths, pipeline payload structs and the divider cell count.
// ----------------------------------------------------------------------------
package biou_pkg;

    localparam int SLOT_W    = 6;
    localparam int COORD_W   = 14;
    localparam int SIZE_W    = COORD_W - 1;
    localparam int EDGE_W    = COORD_W + 1;
    localparam int DIFF_W    = COORD_W + 2;
    localparam int FRAC_W    = 16;
    localparam int COST_W    = FRAC_W + 1;
    localparam int AREA_W    = 2 * SIZE_W;
    localparam int UNI_W     = AREA_W + 1;
    localparam int REM_W     = UNI_W + 1;
    localparam int QUO_W     = FRAC_W + 1;
    localparam int DIV_CELLS = QUO_W;

    localparam logic [COST_W-1:0] COST_ONE = COST_W'(1) << FRAC_W;

    typedef struct packed {
        logic [SLOT_W-1:0] row;
        logic [SLOT_W-1:0] col;
        logic              ovl;
        logic [SIZE_W-1:0] ow;
        logic [SIZE_W-1:0] oh;
        logic [SIZE_W-1:0] tw;
        logic [SIZE_W-1:0] th;
        logic [SIZE_W-1:0] dw;
        logic [SIZE_W-1:0] dh;
    } t_geom;

    typedef struct packed {
        logic [SLOT_W-1:0] row;
        logic [SLOT_W-1:0] col;
        logic [REM_W-1:0]  rem;
        logic [UNI_W-1:0]  den;
        logic [QUO_W-1:0]  quo;
    } t_div;

endpackage

FILE: rtl/box_iou_cost.sv
// ----------------------------------------------------------------------------
// box_iou_cost: association cost of a track box and a detection box
// Returns 1 - IoU in Q1.16 for one box pair, with slot numbers passed on.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid / o_ready carries one box pair per item: slots,
//   left, top, width and height of track and detection. Output channel
//   o_valid / i_ready carries row, column and cost per item, in order.
//   The path holds 21 register stages: one overlap stage, one multiply stage,
//   one union stage, a row of 17 divider cells (one quotient bit each) and
//   the output register, in that order.
//   Throughput is one item per cycle while i_ready stays high; every stage
//   and cell holds its own item, handing it on when its neighbor frees up.
//   When the receiver stalls, items pile up behind the output register,
//   filling bubbles; o_ready falls only once all 21 stages hold an item.
//   Synchronous reset empties every stage; no item survives it.
//   Cost is 65536 without overlap, 0 for identical nonempty boxes.
// ----------------------------------------------------------------------------
module box_iou_cost (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [biou_pkg::SLOT_W-1:0]         i_track_slot,
    input  logic [biou_pkg::SLOT_W-1:0]         i_detection_slot,
    input  logic signed [biou_pkg::COORD_W-1:0] i_track_left,
    input  logic signed [biou_pkg::COORD_W-1:0] i_track_top,
    input  logic [biou_pkg::SIZE_W-1:0]         i_track_width,
    input  logic [biou_pkg::SIZE_W-1:0]         i_track_height,
    input  logic signed [biou_pkg::COORD_W-1:0] i_det_left,
    input  logic signed [biou_pkg::COORD_W-1:0] i_det_top,
    input  logic [biou_pkg::SIZE_W-1:0]         i_det_width,
    input  logic [biou_pkg::SIZE_W-1:0]         i_det_height,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [biou_pkg::SLOT_W-1:0]         o_row_out,
    output logic [biou_pkg::SLOT_W-1:0]         o_col_out,
    output logic [biou_pkg::COST_W-1:0]         o_cost
);

    logic                        geom_valid;
    logic                        geom_ready;
    biou_pkg::t_geom             geom_data;
    logic                        cell_valid [biou_pkg::DIV_CELLS+1];
    logic                        cell_ready [biou_pkg::DIV_CELLS+1];
    biou_pkg::t_div              cell_data  [biou_pkg::DIV_CELLS+1];
    logic                        out_ready;
    logic                        r_valid;
    logic [biou_pkg::SLOT_W-1:0] r_row;
    logic [biou_pkg::SLOT_W-1:0] r_col;
    logic [biou_pkg::COST_W-1:0] r_cost;

    biou_geom u_geom (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_track_slot     (i_track_slot),
        .i_detection_slot (i_detection_slot),
        .i_track_left     (i_track_left),
        .i_track_top      (i_track_top),
        .i_track_width    (i_track_width),
        .i_track_height   (i_track_height),
        .i_det_left       (i_det_left),
        .i_det_top        (i_det_top),
        .i_det_width      (i_det_width),
        .i_det_height     (i_det_height),
        .o_valid          (geom_valid),
        .i_ready          (geom_ready),
        .o_data           (geom_data)
    );

    biou_area u_area (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (geom_valid),
        .o_ready (geom_ready),
        .i_data  (geom_data),
        .o_valid (cell_valid[0]),
        .i_ready (cell_ready[0]),
        .o_data  (cell_data[0])
    );

    for (genvar g = 0; g < biou_pkg::DIV_CELLS; g++) begin : g_cell
        biou_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (cell_valid[g]),
            .o_ready (cell_ready[g]),
            .i_data  (cell_data[g]),
            .o_valid (cell_valid[g+1]),
            .i_ready (cell_ready[g+1]),
            .o_data  (cell_data[g+1])
        );
    end

    assign out_ready                       = !r_valid || i_ready;
    assign cell_ready[biou_pkg::DIV_CELLS] = out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (out_ready) begin
            r_valid <= cell_valid[biou_pkg::DIV_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && cell_valid[biou_pkg::DIV_CELLS]) begin
            r_row  <= cell_data[biou_pkg::DIV_CELLS].row;
            r_col  <= cell_data[biou_pkg::DIV_CELLS].col;
            r_cost <= biou_pkg::COST_ONE - cell_data[biou_pkg::DIV_CELLS].quo;
        end
    end

    assign o_valid   = r_valid;
    assign o_row_out = r_row;
    assign o_col_out = r_col;
    assign o_cost    = r_cost;

endmodule

FILE: rtl/biou_geom.sv
// ----------------------------------------------------------------------------
// biou_geom: overlap rectangle stage
// Clips the two boxes against each other and registers the overlap size.
// ----------------------------------------------------------------------------
module biou_geom (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [biou_pkg::SLOT_W-1:0]         i_track_slot,
    input  logic [biou_pkg::SLOT_W-1:0]         i_detection_slot,
    input  logic signed [biou_pkg::COORD_W-1:0] i_track_left,
    input  logic signed [biou_pkg::COORD_W-1:0] i_track_top,
    input  logic [biou_pkg::SIZE_W-1:0]         i_track_width,
    input  logic [biou_pkg::SIZE_W-1:0]         i_track_height,
    input  logic signed [biou_pkg::COORD_W-1:0] i_det_left,
    input  logic signed [biou_pkg::COORD_W-1:0] i_det_top,
    input  logic [biou_pkg::SIZE_W-1:0]         i_det_width,
    input  logic [biou_pkg::SIZE_W-1:0]         i_det_height,
    output logic                                o_valid,
    input  logic                                i_ready,
    output biou_pkg::t_geom                     o_data
);

    logic                               r_valid;
    biou_pkg::t_geom                    r_data;
    biou_pkg::t_geom                    n_data;
    logic signed [biou_pkg::EDGE_W-1:0] tl, tt, dl, dt, tr, tb, dr, db;
    logic signed [biou_pkg::EDGE_W-1:0] ix, iy, rx, by;
    logic signed [biou_pkg::DIFF_W-1:0] iw, ih;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        tl = biou_pkg::EDGE_W'(i_track_left);
        tt = biou_pkg::EDGE_W'(i_track_top);
        dl = biou_pkg::EDGE_W'(i_det_left);
        dt = biou_pkg::EDGE_W'(i_det_top);
        tr = tl + $signed({2'b00, i_track_width});
        tb = tt + $signed({2'b00, i_track_height});
        dr = dl + $signed({2'b00, i_det_width});
        db = dt + $signed({2'b00, i_det_height});
        ix = (tl > dl) ? tl : dl;
        iy = (tt > dt) ? tt : dt;
        rx = (tr < dr) ? tr : dr;
        by = (tb < db) ? tb : db;
        iw = biou_pkg::DIFF_W'(rx) - biou_pkg::DIFF_W'(ix);
        ih = biou_pkg::DIFF_W'(by) - biou_pkg::DIFF_W'(iy);
        n_data.row = i_track_slot;
        n_data.col = i_detection_slot;
        n_data.ovl = (iw > 0) && (ih > 0);
        n_data.ow  = iw[biou_pkg::SIZE_W-1:0];
        n_data.oh  = ih[biou_pkg::SIZE_W-1:0];
        n_data.tw  = i_track_width;
        n_data.th  = i_track_height;
        n_data.dw  = i_det_width;
        n_data.dh  = i_det_height;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

FILE: rtl/biou_area.sv
// ----------------------------------------------------------------------------
// biou_area: area and union stages
// Multiplies out the three areas, then forms the union as divisor.
// ----------------------------------------------------------------------------
module biou_area (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  biou_pkg::t_geom i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output biou_pkg::t_div  o_data
);

    logic                          r_mul_valid;
    logic                          mul_ready;
    logic [biou_pkg::SLOT_W-1:0]   r_row;
    logic [biou_pkg::SLOT_W-1:0]   r_col;
    logic                          r_ovl;
    logic [biou_pkg::AREA_W-1:0]   r_inter;
    logic [biou_pkg::AREA_W-1:0]   r_at;
    logic [biou_pkg::AREA_W-1:0]   r_ad;
    logic                          r_valid;
    biou_pkg::t_div                r_data;
    biou_pkg::t_div                n_data;
    logic [biou_pkg::UNI_W-1:0]    uni;

    assign mul_ready = !r_valid || i_ready;
    assign o_ready   = !r_mul_valid || mul_ready;
    assign o_valid   = r_valid;
    assign o_data    = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
        end else if (o_ready) begin
            r_mul_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_row   <= i_data.row;
            r_col   <= i_data.col;
            r_ovl   <= i_data.ovl;
            r_inter <= i_data.ow * i_data.oh;
            r_at    <= i_data.tw * i_data.th;
            r_ad    <= i_data.dw * i_data.dh;
        end
    end

    // drop to zero over one when the boxes do not overlap
    always_comb begin
        uni = biou_pkg::UNI_W'(r_at) + biou_pkg::UNI_W'(r_ad)
            - biou_pkg::UNI_W'(r_inter);
        n_data.row = r_row;
        n_data.col = r_col;
        n_data.quo = '0;
        if (r_ovl) begin
            n_data.rem = biou_pkg::REM_W'(r_inter);
            n_data.den = uni;
        end else begin
            n_data.rem = '0;
            n_data.den = biou_pkg::UNI_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (mul_ready) begin
            r_valid <= r_mul_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_ready && r_mul_valid) begin
            r_data <= n_data;
        end
    end

endmodule

FILE: rtl/biou_div_cell.sv
// ----------------------------------------------------------------------------
// biou_div_cell: one restoring division cell
// Resolves one quotient bit, then shifts the partial remainder on.
// ----------------------------------------------------------------------------
module biou_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  biou_pkg::t_div i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output biou_pkg::t_div o_data
);

    logic                        r_valid;
    biou_pkg::t_div              r_data;
    biou_pkg::t_div              n_data;
    logic [biou_pkg::REM_W-1:0]  den_ext;
    logic [biou_pkg::REM_W-1:0]  diff;
    logic                        bit_q;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        den_ext    = biou_pkg::REM_W'(i_data.den);
        bit_q      = i_data.rem >= den_ext;
        diff       = bit_q ? (i_data.rem - den_ext) : i_data.rem;
        n_data.row = i_data.row;
        n_data.col = i_data.col;
        n_data.den = i_data.den;
        n_data.rem = {diff[biou_pkg::REM_W-2:0], 1'b0};
        n_data.quo = {i_data.quo[biou_pkg::QUO_W-2:0], bit_q};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

FILE: rtl/biou_checker.sv
// ----------------------------------------------------------------------------
// biou_checker: port-level checks of the box IoU cost block
// Watches reset, output stalls, cost range and backpressure.
// ----------------------------------------------------------------------------
module biou_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_ready,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [biou_pkg::SLOT_W-1:0] o_row_out,
    input logic [biou_pkg::SLOT_W-1:0] o_col_out,
    input logic [biou_pkg::COST_W-1:0] o_cost
);

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("item present right after reset");

    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_cost)
            && $stable(o_row_out) && $stable(o_col_out))
        else $error("stalled item changed or vanished");

    a_cost_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_cost <= biou_pkg::COST_ONE)
        else $error("cost above one");

    a_full_backpressure : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input refused while output side is free");

endmodule

bind box_iou_cost biou_checker u_biou_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_ready   (o_ready),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_row_out (o_row_out),
    .o_col_out (o_col_out),
    .o_cost    (o_cost)
);

FILE: tb/tb_box_iou_cost.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_box_iou_cost: self-checking bench for the box IoU cost pipeline
// Drives box pairs through the valid/ready input channel, computes the
// expected 1 - IoU cost of every accepted pair in a local model unless the
// directed table gives it, and checks row, column and cost of each output
// item in order. Both channels idle at random with back-to-back bursts in
// between. A directed table of edge cases runs first, then a random mix of
// overlapping, identical, abutting, empty and unconstrained pairs.
// ----------------------------------------------------------------------------
module tb_box_iou_cost;

    localparam int RANDOM_ITEMS = 550;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int COORD_LO     = -(1 << (biou_pkg::COORD_W - 1));
    localparam int COORD_HI     = (1 << (biou_pkg::COORD_W - 1)) - 1;
    localparam int SIZE_HI      = (1 << biou_pkg::SIZE_W) - 1;
    localparam int SLOT_HI      = (1 << biou_pkg::SLOT_W) - 1;
    localparam int NUM_DIRECTED = 18;

    typedef struct packed {
        logic [biou_pkg::SLOT_W-1:0]  ts;
        logic [biou_pkg::SLOT_W-1:0]  ds;
        logic [biou_pkg::COORD_W-1:0] tl;
        logic [biou_pkg::COORD_W-1:0] tt;
        logic [biou_pkg::SIZE_W-1:0]  tw;
        logic [biou_pkg::SIZE_W-1:0]  th;
        logic [biou_pkg::COORD_W-1:0] dl;
        logic [biou_pkg::COORD_W-1:0] dt;
        logic [biou_pkg::SIZE_W-1:0]  dw;
        logic [biou_pkg::SIZE_W-1:0]  dh;
    } t_box_pair;

    typedef struct packed {
        int ts;
        int ds;
        int tl;
        int tt;
        int tw;
        int th;
        int dl;
        int dt;
        int dw;
        int dh;
        int known;
        int cost;
    } t_pair_row;

    typedef struct packed {
        logic [biou_pkg::SLOT_W-1:0] row;
        logic [biou_pkg::SLOT_W-1:0] col;
        logic [biou_pkg::COST_W-1:0] cost;
    } t_cost_entry;

    typedef enum {
        PAIR_RAW,
        PAIR_NEAR,
        PAIR_SAME,
        PAIR_ABUT,
        PAIR_EMPTY
    } t_pair_kind;

    logic                                i_clk            = 1'b0;
    logic                                i_rst_n          = 1'b0;
    logic                                i_valid          = 1'b0;
    logic                                o_ready;
    logic [biou_pkg::SLOT_W-1:0]         i_track_slot     = '0;
    logic [biou_pkg::SLOT_W-1:0]         i_detection_slot = '0;
    logic signed [biou_pkg::COORD_W-1:0] i_track_left     = '0;
    logic signed [biou_pkg::COORD_W-1:0] i_track_top      = '0;
    logic [biou_pkg::SIZE_W-1:0]         i_track_width    = '0;
    logic [biou_pkg::SIZE_W-1:0]         i_track_height   = '0;
    logic signed [biou_pkg::COORD_W-1:0] i_det_left       = '0;
    logic signed [biou_pkg::COORD_W-1:0] i_det_top        = '0;
    logic [biou_pkg::SIZE_W-1:0]         i_det_width      = '0;
    logic [biou_pkg::SIZE_W-1:0]         i_det_height     = '0;
    logic                                o_valid;
    logic                                i_ready          = 1'b0;
    logic [biou_pkg::SLOT_W-1:0]         o_row_out;
    logic [biou_pkg::SLOT_W-1:0]         o_col_out;
    logic [biou_pkg::COST_W-1:0]         o_cost;

    t_cost_entry expected_costs[$];
    t_pair_row   dir_rows [NUM_DIRECTED];
    int          cycles       = 0;
    int          n_errors     = 0;
    int          n_sent       = 0;
    int          n_checked    = 0;
    int          n_overlap    = 0;
    bit          send_burst   = 1'b0;
    bit          drain_burst  = 1'b0;

    box_iou_cost dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_track_slot     (i_track_slot),
        .i_detection_slot (i_detection_slot),
        .i_track_left     (i_track_left),
        .i_track_top      (i_track_top),
        .i_track_width    (i_track_width),
        .i_track_height   (i_track_height),
        .i_det_left       (i_det_left),
        .i_det_top        (i_det_top),
        .i_det_width      (i_det_width),
        .i_det_height     (i_det_height),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_row_out        (o_row_out),
        .o_col_out        (o_col_out),
        .o_cost           (o_cost)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d items pending", $time, cycles,
                     expected_costs.size());
            $display("box_iou_cost verification failed");
            $finish;
        end
    end

    function automatic logic [biou_pkg::COST_W-1:0] pair_cost(t_box_pair p);
        longint tl, tt, dl, dt, tw, th, dw, dh;
        longint ow, oh, inter, uni, iou;
        logic [biou_pkg::COST_W-1:0] c;
        tl = $signed(p.tl);
        tt = $signed(p.tt);
        dl = $signed(p.dl);
        dt = $signed(p.dt);
        tw = p.tw;
        th = p.th;
        dw = p.dw;
        dh = p.dh;
        ow = ((tl + tw < dl + dw) ? tl + tw : dl + dw) - ((tl > dl) ? tl : dl);
        oh = ((tt + th < dt + dh) ? tt + th : dt + dh) - ((tt > dt) ? tt : dt);
        c = biou_pkg::COST_ONE;
        if (ow > 0 && oh > 0) begin
            inter = ow * oh;
            uni   = tw * th + dw * dh - inter;
            if (uni != 0) begin
                iou = (inter << biou_pkg::FRAC_W) / uni;
                if (iou > longint'(biou_pkg::COST_ONE))
                    iou = longint'(biou_pkg::COST_ONE);
                c = biou_pkg::COST_ONE - biou_pkg::COST_W'(iou);
            end
        end
        return c;
    endfunction

    // hold the pair until taken, then log what the block owes us
    task automatic send_pair(t_box_pair p, bit known,
                             logic [biou_pkg::COST_W-1:0] known_cost);
        int gap;
        t_cost_entry e;
        if ($urandom_range(0, 15) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_track_slot     <= p.ts;
        i_detection_slot <= p.ds;
        i_track_left     <= p.tl;
        i_track_top      <= p.tt;
        i_track_width    <= p.tw;
        i_track_height   <= p.th;
        i_det_left       <= p.dl;
        i_det_top        <= p.dt;
        i_det_width      <= p.dw;
        i_det_height     <= p.dh;
        do @(posedge i_clk); while (!o_ready);
        e.row  = p.ts;
        e.col  = p.ds;
        e.cost = known ? known_cost : pair_cost(p);
        if (e.cost != biou_pkg::COST_ONE)
            n_overlap++;
        expected_costs.insert(expected_costs.size(), e);
        n_sent++;
    endtask

    initial begin
        int stall;
        t_cost_entry e;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if ($urandom_range(0, 15) == 0)
                drain_burst = !drain_burst;
            stall = drain_burst ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            if (expected_costs.size() == 0) begin
                $display("%0t: unexpected item row %0d col %0d cost %0d", $time,
                         o_row_out, o_col_out, o_cost);
                n_errors++;
            end else begin
                e = expected_costs.pop_front();
                n_checked++;
                if (o_row_out !== e.row) begin
                    $display("%0t: row mismatch, expected %0d actual %0d", $time,
                             e.row, o_row_out);
                    n_errors++;
                end
                if (o_col_out !== e.col) begin
                    $display("%0t: col mismatch, expected %0d actual %0d", $time,
                             e.col, o_col_out);
                    n_errors++;
                end
                if (o_cost !== e.cost) begin
                    $display("%0t: cost mismatch (row %0d col %0d), expected %0d actual %0d",
                             $time, e.row, e.col, e.cost, o_cost);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        t_pair_row  r;
        t_box_pair  p;
        t_pair_kind kind;
        int roll, tl, tt, tw, th, dl, dt, dw, dh;

        // ts ds | track l t w h | det l t w h | known cost
        dir_rows = '{
            '{0, 0, 0, 0, 10, 10, 0, 0, 10, 10, 1, 0},
            '{63, 63, -8192, -8192, 8191, 8191, -8192, -8192, 8191, 8191, 1, 0},
            '{1, 2, 8191, 8191, 8191, 8191, 8191, 8191, 8191, 8191, 1, 0},
            '{5, 6, 0, 0, 0, 10, 0, 0, 10, 10, 1, 65536},
            '{7, 8, 0, 0, 10, 10, 0, 0, 10, 0, 1, 65536},
            '{9, 10, 0, 0, 10, 10, 10, 0, 10, 10, 1, 65536},
            '{11, 12, 0, 0, 10, 10, 0, 10, 10, 10, 1, 65536},
            '{13, 14, -8192, -8192, 8191, 8191, 8191, 8191, 8191, 8191, 1, 65536},
            '{15, 16, 0, 0, 0, 0, 0, 0, 0, 0, 1, 65536},
            '{6, 7, -8192, 8191, 8191, 0, -8192, 8191, 8191, 8191, 1, 65536},
            '{21, 42, -8192, 0, 1, 1, -8192, 0, 1, 1, 1, 0},
            '{42, 21, 0, 0, 2, 1, 1, 0, 2, 1, 0, 0},
            '{0, 63, 0, 0, 8191, 8191, 100, 100, 1, 1, 0, 0},
            '{63, 0, -100, -50, 300, 200, -20, -80, 150, 400, 0, 0},
            '{33, 44, 0, 0, 8191, 8191, 1, 1, 8191, 8191, 0, 0},
            '{1, 1, -5, -5, 10, 10, 0, 0, 10, 10, 0, 0},
            '{2, 3, 8000, -8192, 191, 8191, 8100, -8000, 8191, 100, 0, 0},
            '{4, 5, 0, 0, 10, 10, 2, 2, 5, 5, 0, 0}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            r    = dir_rows[k];
            p.ts = r.ts[biou_pkg::SLOT_W-1:0];
            p.ds = r.ds[biou_pkg::SLOT_W-1:0];
            p.tl = r.tl[biou_pkg::COORD_W-1:0];
            p.tt = r.tt[biou_pkg::COORD_W-1:0];
            p.tw = r.tw[biou_pkg::SIZE_W-1:0];
            p.th = r.th[biou_pkg::SIZE_W-1:0];
            p.dl = r.dl[biou_pkg::COORD_W-1:0];
            p.dt = r.dt[biou_pkg::COORD_W-1:0];
            p.dw = r.dw[biou_pkg::SIZE_W-1:0];
            p.dh = r.dh[biou_pkg::SIZE_W-1:0];
            send_pair(p, r.known != 0, r.cost[biou_pkg::COST_W-1:0]);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(0, 9);
            kind = (roll < 2) ? PAIR_RAW : (roll < 7) ? PAIR_NEAR :
                   (roll == 7) ? PAIR_SAME : (roll == 8) ? PAIR_ABUT : PAIR_EMPTY;
            tl = int'($urandom_range(0, 2 * COORD_HI + 1)) + COORD_LO;
            tt = int'($urandom_range(0, 2 * COORD_HI + 1)) + COORD_LO;
            tw = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, SIZE_HI))
                                             : int'($urandom_range(1, 64));
            th = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, SIZE_HI))
                                             : int'($urandom_range(1, 64));
            dw = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, SIZE_HI))
                                             : int'($urandom_range(1, 64));
            dh = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, SIZE_HI))
                                             : int'($urandom_range(1, 64));
            dl = tl - dw + int'($urandom_range(0, tw + dw));
            dt = tt - dh + int'($urandom_range(0, th + dh));
            case (kind)
                PAIR_RAW: begin
                    tl = int'($urandom_range(0, 2 * COORD_HI + 1)) + COORD_LO;
                    dl = int'($urandom_range(0, 2 * COORD_HI + 1)) + COORD_LO;
                    dt = int'($urandom_range(0, 2 * COORD_HI + 1)) + COORD_LO;
                    tw = $urandom_range(0, SIZE_HI);
                    th = $urandom_range(0, SIZE_HI);
                    dw = $urandom_range(0, SIZE_HI);
                    dh = $urandom_range(0, SIZE_HI);
                end
                PAIR_SAME: begin
                    dl = tl;
                    dt = tt;
                    dw = tw;
                    dh = th;
                end
                PAIR_ABUT: begin
                    if ($urandom_range(0, 1) == 0)
                        dl = tl + tw;
                    else
                        dt = tt + th;
                end
                PAIR_EMPTY: begin
                    case ($urandom_range(0, 3))
                        0: tw = 0;
                        1: th = 0;
                        2: dw = 0;
                        default: dh = 0;
                    endcase
                end
                default: ;
            endcase
            if (dl > COORD_HI) dl = COORD_HI;
            if (dl < COORD_LO) dl = COORD_LO;
            if (dt > COORD_HI) dt = COORD_HI;
            if (dt < COORD_LO) dt = COORD_LO;
            p.ts = biou_pkg::SLOT_W'($urandom_range(0, SLOT_HI));
            p.ds = biou_pkg::SLOT_W'($urandom_range(0, SLOT_HI));
            p.tl = tl[biou_pkg::COORD_W-1:0];
            p.tt = tt[biou_pkg::COORD_W-1:0];
            p.tw = tw[biou_pkg::SIZE_W-1:0];
            p.th = th[biou_pkg::SIZE_W-1:0];
            p.dl = dl[biou_pkg::COORD_W-1:0];
            p.dt = dt[biou_pkg::COORD_W-1:0];
            p.dw = dw[biou_pkg::SIZE_W-1:0];
            p.dh = dh[biou_pkg::SIZE_W-1:0];
            send_pair(p, 1'b0, '0);
        end
        i_valid <= 1'b0;

        while (expected_costs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d box pairs (%0d directed), %0d with overlap; %0d results checked.",
                 n_sent, NUM_DIRECTED, n_overlap, n_checked);
        $display("Errors: %0d over %0d cycles.", n_errors, cycles);
        if (n_errors == 0 && expected_costs.size() == 0) begin
            $display("box_iou_cost verification clean");
        end else begin
            $display("box_iou_cost verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/biou_pkg.sv
rtl/biou_geom.sv
rtl/biou_area.sv
rtl/biou_div_cell.sv
rtl/box_iou_cost.sv
rtl/biou_checker.sv
tb/tb_box_iou_cost.sv
